@@ hdl/skbh_pkg.sv @@
// Shared constants, types and character and position mapping functions for the symbol key hash block.
`timescale 1ns / 1ps
package skbh_pkg;

	localparam int CHAR_W   = 8;
	localparam int KEY_W    = 32;
	localparam int BUCKET_W = 16;
	localparam int DIGIT_W  = 6;
	localparam int WEIGHT_W = 17;
	localparam int PROD_W   = DIGIT_W + WEIGHT_W;
	localparam int GROUP_W  = 2;
	localparam int STEP_W   = $clog2(KEY_W);

	localparam logic [BUCKET_W-1:0] BUCKET_RESET = BUCKET_W'(1024);

	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
	} key_req_t;

	typedef struct packed {
		logic                vld;
		logic [KEY_W-1:0]    key;
		logic [BUCKET_W-1:0] index;
	} result_t;

	function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = CHAR_W'(43);
		case (c) inside
			[8'h30:8'h39]: d = c - 8'h2f;
			[8'h61:8'h7a]: d = c - 8'h56;
			[8'h41:8'h5a]: d = c - 8'h36;
			8'h5f:         d = CHAR_W'(37);
			8'h23:         d = CHAR_W'(38);
			8'h40:         d = CHAR_W'(39);
			8'h24:         d = CHAR_W'(40);
			8'h2f:         d = CHAR_W'(41);
			8'h3c, 8'h3e:  d = CHAR_W'(42);
			default:       d = CHAR_W'(43);
		endcase
		return d[DIGIT_W-1:0];
	endfunction

	function automatic logic [WEIGHT_W-1:0] weight_of(input logic [GROUP_W-1:0] pos);
		logic [WEIGHT_W-1:0] w;
		case (pos)
			2'd0:    w = WEIGHT_W'(1);
			2'd1:    w = WEIGHT_W'(44);
			2'd2:    w = WEIGHT_W'(1936);
			2'd3:    w = WEIGHT_W'(85184);
			default: w = WEIGHT_W'(1);
		endcase
		return w;
	endfunction

endpackage

@@ hdl/skbh_acc.sv @@
// Character accumulator that builds the symbol key and holds a finished key for the divider.
`timescale 1ns / 1ps
module skbh_acc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [skbh_pkg::CHAR_W-1:0]  char_code,
	input  logic                         last_char,
	output skbh_pkg::key_req_t           key_req,
	input  logic                         key_take
);
	import skbh_pkg::*;

	logic [KEY_W-1:0]   acc_q;
	logic [GROUP_W-1:0] pos_q;
	logic               pend_vld_q;
	logic [KEY_W-1:0]   pend_key_q;
	logic [PROD_W-1:0]  prod;
	logic [KEY_W-1:0]   key_next;
	logic               accept;

	assign prod     = PROD_W'(digit_of(char_code)) * PROD_W'(weight_of(pos_q));
	assign key_next = acc_q + KEY_W'(prod);
	assign in_ready = !pend_vld_q;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			pos_q      <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				if (last_char) begin
					acc_q      <= '0;
					pos_q      <= '0;
					pend_vld_q <= 1'b1;
				end else begin
					acc_q <= key_next;
					pos_q <= pos_q + GROUP_W'(1);
				end
			end else if (key_take) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_char) begin
			pend_key_q <= key_next;
		end
	end

	assign key_req.vld = pend_vld_q;
	assign key_req.key = pend_key_q;

endmodule

@@ hdl/skbh_mod.sv @@
// Bit-serial restoring divider that reduces a key modulo the bucket count and holds the result.
`timescale 1ns / 1ps
module skbh_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  skbh_pkg::key_req_t            key_req,
	output logic                          key_take,
	input  logic [skbh_pkg::BUCKET_W-1:0] bucket_count,
	output skbh_pkg::result_t             result,
	input  logic                          out_ready
);
	import skbh_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} mod_state_t;

	mod_state_t          state_q;
	logic [STEP_W-1:0]   step_q;
	logic [KEY_W-1:0]    shift_q;
	logic [KEY_W-1:0]    key_q;
	logic [BUCKET_W-1:0] div_q;
	logic [BUCKET_W-1:0] rem_q;
	logic [BUCKET_W:0]   trial;
	logic [BUCKET_W:0]   diff;

	assign key_take = key_req.vld && (state_q == ST_IDLE);
	assign trial    = {rem_q, shift_q[KEY_W-1]};
	assign diff     = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (key_take) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(KEY_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (key_take) begin
			shift_q <= key_req.key;
			key_q   <= key_req.key;
			div_q   <= bucket_count;
			rem_q   <= '0;
		end else if (state_q == ST_RUN) begin
			shift_q <= {shift_q[KEY_W-2:0], 1'b0};
			if (!diff[BUCKET_W]) begin
				rem_q <= diff[BUCKET_W-1:0];
			end else begin
				rem_q <= trial[BUCKET_W-1:0];
			end
		end
	end

	assign result.vld   = (state_q == ST_DONE);
	assign result.key   = key_q;
	assign result.index = (div_q == '0) ? '0 : rem_q;

endmodule

@@ hdl/symbol_key_hash_and_bucket_top.sv @@
// Top level of the symbol key hash and bucket index block.
//
// The input channel takes one character per request on char_code, with last_char
// set on the final character of a symbol. Characters are accepted one per cycle while the holding register is empty.
// After the last character the finished key waits in a holding register, and the
// input stays stalled for as long as that register is full.
// A bit-serial divider takes the key and reduces it modulo bucket_count, one
// quotient bit per cycle. The output request carries key_value and bucket_index.
// The divider takes a new key only once the receiver has taken the previous
// result; until then the next key waits in the holding register.
// While the receiver stalls, the result is held unchanged, the divider waits,
// and the next symbol is still accumulated until its key fills the holding register.
// bucket_count is written through cfg_we and cfg_wdata; the user must do so only while
// the block is idle, which the block does not enforce; a count of zero gives
// bucket_index zero. Reset clears the partial key and group position, empties the
// holding register and divider, and sets bucket_count to 1024.
`timescale 1ns / 1ps
module symbol_key_hash_and_bucket_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [skbh_pkg::BUCKET_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [skbh_pkg::CHAR_W-1:0]   char_code,
	input  logic                          last_char,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [skbh_pkg::KEY_W-1:0]    key_value,
	output logic [skbh_pkg::BUCKET_W-1:0] bucket_index
);
	import skbh_pkg::*;

	logic [BUCKET_W-1:0] bucket_count_q;
	key_req_t            key_req;
	logic                key_take;
	result_t             result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_RESET;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	skbh_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.last_char (last_char),
		.key_req   (key_req),
		.key_take  (key_take)
	);

	skbh_mod u_mod (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_req      (key_req),
		.key_take     (key_take),
		.bucket_count (bucket_count_q),
		.result       (result),
		.out_ready    (out_ready)
	);

	assign out_valid    = result.vld;
	assign key_value    = result.key;
	assign bucket_index = result.index;

endmodule

@@ hdl/skbh_checker.sv @@
// Port-level checker for the symbol key hash block, bound to the top level.
`timescale 1ns / 1ps
module skbh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          last_char,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [skbh_pkg::KEY_W-1:0]    key_value,
	input logic [skbh_pkg::BUCKET_W-1:0] bucket_index
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output request dropped before it was taken.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(key_value) && $stable(bucket_index))
		else $error("Output payload changed while stalled.");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_char |=> !in_ready)
		else $error("Input not stalled after the last character of a symbol.");

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("Result appeared without a full division in between.");

endmodule

bind symbol_key_hash_and_bucket_top skbh_checker u_skbh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.last_char    (last_char),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.key_value    (key_value),
	.bucket_index (bucket_index)
);
